// ----- rtl/pcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, field widths and term tables for the pose composition block.
package pcc_pkg;

    localparam int POS_W = 32;
    localparam int ROT_W = 16;

    // Idle cycles between phases: product, accumulate and round stages must drain.
    localparam logic [1:0] PIPE_GAP = 2'd3;

    // Component index of the last position write-back.
    localparam logic [1:0] POS_LAST = 2'd2;

    typedef enum logic [1:0] {
        PH_ROT  = 2'd0,
        PH_TVEC = 2'd1,
        PH_POS  = 2'd2
    } t_phase;

    // One multiply-accumulate term: wide operand index, narrow operand index, subtract.
    typedef struct packed {
        logic [1:0] aidx;
        logic [1:0] bidx;
        logic       neg;
    } t_term;

    typedef struct packed {
        logic       vld;
        t_phase     phase;
        logic [1:0] comp;
        logic [1:0] aidx;
        logic [1:0] bidx;
        logic       neg;
        logic       first;
        logic       last;
    } t_issue;

    typedef struct packed {
        logic       vld;
        t_phase     phase;
        logic [1:0] idx;
    } t_wb;

    // new_rot = in_rot x base_rot; wide side in_rot, narrow side base_rot.
    localparam t_term ROT_TAB [16] = '{
        '{2'd3, 2'd0, 1'b0}, '{2'd0, 2'd3, 1'b0}, '{2'd1, 2'd2, 1'b0}, '{2'd2, 2'd1, 1'b1},
        '{2'd3, 2'd1, 1'b0}, '{2'd0, 2'd2, 1'b1}, '{2'd1, 2'd3, 1'b0}, '{2'd2, 2'd0, 1'b0},
        '{2'd3, 2'd2, 1'b0}, '{2'd0, 2'd1, 1'b0}, '{2'd1, 2'd0, 1'b1}, '{2'd2, 2'd3, 1'b0},
        '{2'd3, 2'd3, 1'b0}, '{2'd0, 2'd0, 1'b1}, '{2'd1, 2'd1, 1'b1}, '{2'd2, 2'd2, 1'b1}
    };

    // t = new_rot x (pos, 0); wide side pos, narrow side new_rot. Fourth term unused.
    localparam t_term TVEC_TAB [16] = '{
        '{2'd0, 2'd3, 1'b0}, '{2'd2, 2'd1, 1'b0}, '{2'd1, 2'd2, 1'b1}, '{2'd0, 2'd0, 1'b0},
        '{2'd1, 2'd3, 1'b0}, '{2'd2, 2'd0, 1'b1}, '{2'd0, 2'd2, 1'b0}, '{2'd0, 2'd0, 1'b0},
        '{2'd2, 2'd3, 1'b0}, '{2'd1, 2'd0, 1'b0}, '{2'd0, 2'd1, 1'b1}, '{2'd0, 2'd0, 1'b0},
        '{2'd0, 2'd0, 1'b1}, '{2'd1, 2'd1, 1'b1}, '{2'd2, 2'd2, 1'b1}, '{2'd0, 2'd0, 1'b0}
    };

    // u = t x conj(new_rot), vector part only; conjugate sign folded into neg.
    localparam t_term POS_TAB [16] = '{
        '{2'd3, 2'd0, 1'b1}, '{2'd0, 2'd3, 1'b0}, '{2'd1, 2'd2, 1'b1}, '{2'd2, 2'd1, 1'b0},
        '{2'd3, 2'd1, 1'b1}, '{2'd0, 2'd2, 1'b0}, '{2'd1, 2'd3, 1'b0}, '{2'd2, 2'd0, 1'b1},
        '{2'd3, 2'd2, 1'b1}, '{2'd0, 2'd1, 1'b1}, '{2'd1, 2'd0, 1'b0}, '{2'd2, 2'd3, 1'b0},
        '{2'd0, 2'd0, 1'b0}, '{2'd0, 2'd0, 1'b0}, '{2'd0, 2'd0, 1'b0}, '{2'd0, 2'd0, 1'b0}
    };

    function automatic t_term term_sel(input t_phase ph, input logic [1:0] comp,
                                       input logic [1:0] term);
        t_term e;
        unique case (ph)
            PH_ROT:  e = ROT_TAB[{comp, term}];
            PH_TVEC: e = TVEC_TAB[{comp, term}];
            PH_POS:  e = POS_TAB[{comp, term}];
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pcc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for pose items and pose results.
interface pcc_in_if;
    import pcc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [POS_W-1:0] in_pos_x;
    logic signed [POS_W-1:0] in_pos_y;
    logic signed [POS_W-1:0] in_pos_z;
    logic signed [ROT_W-1:0] in_rot_x;
    logic signed [ROT_W-1:0] in_rot_y;
    logic signed [ROT_W-1:0] in_rot_z;
    logic signed [ROT_W-1:0] in_rot_w;

    modport source (output valid, func, in_pos_x, in_pos_y, in_pos_z,
                    in_rot_x, in_rot_y, in_rot_z, in_rot_w, input ready);
    modport sink (input valid, func, in_pos_x, in_pos_y, in_pos_z,
                  in_rot_x, in_rot_y, in_rot_z, in_rot_w, output ready);
endinterface

interface pcc_out_if;
    import pcc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] out_pos_x;
    logic signed [POS_W-1:0] out_pos_y;
    logic signed [POS_W-1:0] out_pos_z;
    logic signed [ROT_W-1:0] out_rot_x;
    logic signed [ROT_W-1:0] out_rot_y;
    logic signed [ROT_W-1:0] out_rot_z;
    logic signed [ROT_W-1:0] out_rot_w;

    modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                    out_rot_x, out_rot_y, out_rot_z, out_rot_w, input ready);
    modport sink (input valid, out_pos_x, out_pos_y, out_pos_z,
                  out_rot_x, out_rot_y, out_rot_z, out_rot_w, output ready);
endinterface
`default_nettype wire

// ----- rtl/pcc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Term sequencer: walks phases, components, terms; one multiply per cycle outside gaps.
module pcc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output pcc_pkg::t_issue o_issue
);
    import pcc_pkg::*;

    logic       r_run;
    logic [1:0] r_gap;
    t_phase     r_phase;
    logic [1:0] r_comp;
    logic [1:0] r_term;

    logic       w_last_term;
    logic       w_last_comp;
    t_phase     w_next_phase;
    t_term      w_tt;

    assign w_last_term = (r_term == ((r_phase == PH_TVEC) ? 2'd2 : 2'd3));
    assign w_last_comp = (r_comp == ((r_phase == PH_POS) ? 2'd2 : 2'd3));

    always_comb begin
        unique case (r_phase)
            PH_ROT:  w_next_phase = PH_TVEC;
            PH_TVEC: w_next_phase = PH_POS;
            default: w_next_phase = PH_POS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_gap   <= 2'd0;
            r_phase <= PH_ROT;
            r_comp  <= 2'd0;
            r_term  <= 2'd0;
        end else if (i_start) begin
            r_run   <= 1'b1;
            r_gap   <= 2'd0;
            r_phase <= PH_ROT;
            r_comp  <= 2'd0;
            r_term  <= 2'd0;
        end else if (r_run) begin
            if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end else if (w_last_term) begin
                r_term <= 2'd0;
                if (w_last_comp) begin
                    r_comp <= 2'd0;
                    if (r_phase == PH_POS) begin
                        r_run <= 1'b0;
                    end else begin
                        // let the previous phase reach its registers before reading them
                        r_phase <= w_next_phase;
                        r_gap   <= PIPE_GAP;
                    end
                end else begin
                    r_comp <= r_comp + 2'd1;
                end
            end else begin
                r_term <= r_term + 2'd1;
            end
        end
    end

    assign w_tt = term_sel(r_phase, r_comp, r_term);

    always_comb begin
        o_issue.vld   = r_run && (r_gap == 2'd0);
        o_issue.phase = r_phase;
        o_issue.comp  = r_comp;
        o_issue.aidx  = w_tt.aidx;
        o_issue.bidx  = w_tt.bidx;
        o_issue.neg   = w_tt.neg;
        o_issue.first = (r_term == 2'd0);
        o_issue.last  = w_last_term;
    end

endmodule
`default_nettype wire

// ----- rtl/pcc_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared multiplier, accumulator and round-half-up stage.
module pcc_mac #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int A_W            = 36
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcc_pkg::t_issue                   i_issue,
    input  logic signed [A_W-1:0]             i_a,
    input  logic signed [pcc_pkg::ROT_W-1:0]  i_b,
    output pcc_pkg::t_wb                      o_wb,
    output logic signed [A_W+pcc_pkg::ROT_W:0] o_wb_val
);
    import pcc_pkg::*;

    localparam int PW = A_W + ROT_W;
    localparam int AW = PW + 1;
    localparam logic signed [AW:0] HALF = (AW + 1)'(1) << (QUAT_FRAC_BITS - 1);

    logic signed [PW-1:0] r_prod;
    t_issue               r_c1;
    logic signed [AW-1:0] r_acc;
    t_wb                  r_c2;
    logic signed [AW-1:0] r_rnd;
    t_wb                  r_c3;

    logic signed [AW-1:0] w_prod_ext;
    logic signed [AW-1:0] w_addend;
    logic signed [AW-1:0] w_acc_base;
    logic signed [AW:0]   w_rsum;
    logic signed [AW:0]   w_rsh;

    assign w_prod_ext = AW'(r_prod);
    assign w_addend   = r_c1.neg ? -w_prod_ext : w_prod_ext;
    assign w_acc_base = r_c1.first ? '0 : r_acc;
    // floor((acc + half) / 2^F) is the arithmetic shift of the biased sum
    assign w_rsum     = (AW + 1)'(r_acc) + HALF;
    assign w_rsh      = w_rsum >>> QUAT_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.vld <= 1'b0;
            r_c2.vld <= 1'b0;
            r_c3.vld <= 1'b0;
        end else begin
            r_c1     <= i_issue;
            r_c2.vld <= r_c1.vld && r_c1.last;
            r_c3.vld <= r_c2.vld;
        end
        r_prod <= PW'(i_a) * PW'(i_b);
        if (r_c1.vld) begin
            r_acc <= w_acc_base + w_addend;
        end
        r_c2.phase <= r_c1.phase;
        r_c2.idx   <= r_c1.comp;
        r_c3.phase <= r_c2.phase;
        r_c3.idx   <= r_c2.idx;
        r_rnd      <= w_rsh[AW-1:0];
    end

    assign o_wb     = r_c3;
    assign o_wb_val = r_rnd;

endmodule
`default_nettype wire

// ----- rtl/pose_chain_compose.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the running pose composer: state, operand selection and channels.
//
// Input channel i_in carries one pose (position Q16.16, quaternion Q2.14) and func.
// func = 1 loads the pose as the stored pose; func = 0 composes it onto the stored
// pose: rotation first (input times stored), then the input position is rotated by
// the new rotation and added to the stored position with saturation.
// Every item produces one result on o_out, the new stored pose.
// A compose item runs 40 multiplies through one shared multiplier, with a pipeline
// drain between the rotation, rotated-vector and position phases; the result is then
// registered, and the next item is taken only once the block is idle again.
// A load item goes straight to the output register.
// i_in.ready is high only while the block is idle; one item is worked at a time.
// The result sits in an output register; if o_out stalls, the block holds the
// next finished pose until the output register is free, then goes idle again.
// Reset sets the stored pose to zero position and identity rotation and drops
// any pending result.
module pose_chain_compose #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcc_in_if.sink    i_in,
    pcc_out_if.source o_out
);
    import pcc_pkg::*;

    localparam int TW = 50 - QUAT_FRAC_BITS;
    localparam int MA = (TW > POS_W) ? TW : POS_W;
    localparam int AW = MA + ROT_W + 1;
    localparam logic signed [ROT_W-1:0] ROT_ONE =
        (QUAT_FRAC_BITS > ROT_W - 2) ? {1'b0, {(ROT_W - 1){1'b1}}}
                                     : ROT_W'(2 ** QUAT_FRAC_BITS);
    localparam logic signed [AW-1:0] RMAX = {{(AW - ROT_W + 1){1'b0}}, {(ROT_W - 1){1'b1}}};
    localparam logic signed [AW-1:0] RMIN = {{(AW - ROT_W + 1){1'b1}}, {(ROT_W - 1){1'b0}}};
    localparam logic signed [AW:0]   PMAX = {{(AW - POS_W + 2){1'b0}}, {(POS_W - 1){1'b1}}};
    localparam logic signed [AW:0]   PMIN = {{(AW - POS_W + 2){1'b1}}, {(POS_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    logic signed [POS_W-1:0] r_in_pos   [3];
    logic signed [ROT_W-1:0] r_in_rot   [4];
    logic signed [POS_W-1:0] r_base_pos [3];
    logic signed [ROT_W-1:0] r_base_rot [4];
    logic signed [ROT_W-1:0] r_rot_new  [4];
    logic signed [TW-1:0]    r_t        [4];
    logic signed [POS_W-1:0] r_out_pos  [3];
    logic signed [ROT_W-1:0] r_out_rot  [4];

    t_issue                  w_issue;
    t_wb                     w_wb;
    logic signed [AW-1:0]    w_wb_val;
    logic signed [MA-1:0]    w_a;
    logic signed [ROT_W-1:0] w_b;
    logic signed [ROT_W-1:0] w_rot_sat;
    logic signed [AW:0]      w_pos_sum;
    logic signed [POS_W-1:0] w_pos_sat;
    logic                    w_accept;
    logic                    w_run_done;
    logic                    w_out_load;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_run_done = w_wb.vld && (w_wb.phase == PH_POS) && (w_wb.idx == POS_LAST);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    pcc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !i_in.func),
        .o_issue (w_issue)
    );

    always_comb begin
        case (w_issue.phase)
            PH_ROT:  w_a = MA'(r_in_rot[w_issue.aidx]);
            PH_TVEC: w_a = MA'(r_in_pos[w_issue.aidx]);
            PH_POS:  w_a = MA'(r_t[w_issue.aidx]);
            default: w_a = '0;
        endcase
        w_b = (w_issue.phase == PH_ROT) ? r_base_rot[w_issue.bidx] : r_rot_new[w_issue.bidx];
    end

    pcc_mac #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .A_W            (MA)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (w_issue),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_wb     (w_wb),
        .o_wb_val (w_wb_val)
    );

    // saturate rounded sums onto the stored formats
    always_comb begin
        if (w_wb_val > RMAX) begin
            w_rot_sat = RMAX[ROT_W-1:0];
        end else if (w_wb_val < RMIN) begin
            w_rot_sat = RMIN[ROT_W-1:0];
        end else begin
            w_rot_sat = w_wb_val[ROT_W-1:0];
        end
        w_pos_sum = (AW + 1)'(r_base_pos[w_wb.idx]) + (AW + 1)'(w_wb_val);
        if (w_pos_sum > PMAX) begin
            w_pos_sat = PMAX[POS_W-1:0];
        end else if (w_pos_sum < PMIN) begin
            w_pos_sat = PMIN[POS_W-1:0];
        end else begin
            w_pos_sat = w_pos_sum[POS_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_in.func ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_run_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_out_load) begin
            r_out_pos <= r_base_pos;
            r_out_rot <= r_base_rot;
        end
    end

    // stored pose
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pos[0] <= '0;
            r_base_pos[1] <= '0;
            r_base_pos[2] <= '0;
            r_base_rot[0] <= '0;
            r_base_rot[1] <= '0;
            r_base_rot[2] <= '0;
            r_base_rot[3] <= ROT_ONE;
        end else begin
            if (w_accept && i_in.func) begin
                r_base_pos[0] <= i_in.in_pos_x;
                r_base_pos[1] <= i_in.in_pos_y;
                r_base_pos[2] <= i_in.in_pos_z;
                r_base_rot[0] <= i_in.in_rot_x;
                r_base_rot[1] <= i_in.in_rot_y;
                r_base_rot[2] <= i_in.in_rot_z;
                r_base_rot[3] <= i_in.in_rot_w;
            end
            if (w_wb.vld && (w_wb.phase == PH_POS)) begin
                r_base_pos[w_wb.idx] <= w_pos_sat;
            end
            // commit the new rotation once the last position lands
            if (w_run_done) begin
                r_base_rot <= r_rot_new;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_pos[0] <= i_in.in_pos_x;
            r_in_pos[1] <= i_in.in_pos_y;
            r_in_pos[2] <= i_in.in_pos_z;
            r_in_rot[0] <= i_in.in_rot_x;
            r_in_rot[1] <= i_in.in_rot_y;
            r_in_rot[2] <= i_in.in_rot_z;
            r_in_rot[3] <= i_in.in_rot_w;
        end
        if (w_wb.vld && (w_wb.phase == PH_ROT)) begin
            r_rot_new[w_wb.idx] <= w_rot_sat;
        end
        if (w_wb.vld && (w_wb.phase == PH_TVEC)) begin
            r_t[w_wb.idx] <= w_wb_val[TW-1:0];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_pos_x = r_out_pos[0];
    assign o_out.out_pos_y = r_out_pos[1];
    assign o_out.out_pos_z = r_out_pos[2];
    assign o_out.out_rot_x = r_out_rot[0];
    assign o_out.out_rot_y = r_out_rot[1];
    assign o_out.out_rot_z = r_out_rot[2];
    assign o_out.out_rot_w = r_out_rot[3];

`ifndef SYNTH
    a_no_issue_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_issue.vld)
        else $error("multiply issued while idle");

    a_wb_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb.vld |-> (r_state == ST_RUN))
        else $error("write-back outside a compose run");

    a_load_goes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.func) |=> (r_state == ST_OUT))
        else $error("load transfer did not go straight to output");

    a_base_rot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && ($past(r_state) == ST_RUN)) |->
        $stable({r_base_rot[0], r_base_rot[1], r_base_rot[2], r_base_rot[3]}))
        else $error("stored rotation changed during a compose run");
`endif

endmodule
`default_nettype wire
